// ----- rtl/core/stid_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package stid_pkg;

    // table geometry
    localparam int ENTRIES     = 16;
    localparam int SLOT_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int ID_W        = 48;
    localparam int CNT_W       = 8;
    localparam int ZONE_W      = 5;
    localparam int ZONE_IN_W   = 8;
    localparam int FIRST_ZONE  = 3;
    localparam logic [CNT_W-1:0] LIMIT_RESET = 8'd84;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // input action codes
    localparam logic [2:0] ACT_LOOKUP = 3'd0;
    localparam logic [2:0] ACT_ADD    = 3'd1;
    localparam logic [2:0] ACT_DELETE = 3'd2;
    localparam logic [2:0] ACT_TICK   = 3'd3;
    localparam logic [2:0] ACT_REPORT = 3'd4;

    // internal operation codes
    localparam logic [2:0] OP_LOOKUP = 3'd0;
    localparam logic [2:0] OP_ADD    = 3'd1;
    localparam logic [2:0] OP_DELETE = 3'd2;
    localparam logic [2:0] OP_TICK   = 3'd3;
    localparam logic [2:0] OP_REPORT = 3'd4;
    localparam logic [2:0] OP_BAD    = 3'd5;

    // result kinds and status
    localparam logic [1:0] KIND_ANSWER = 2'd0;
    localparam logic [1:0] KIND_EVENT  = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;
    localparam logic       STAT_OK     = 1'b0;
    localparam logic       STAT_FAIL   = 1'b1;

    typedef struct packed {
        logic [2:0]           action;
        logic [ID_W-1:0]      sensor_id;
        logic [ZONE_IN_W-1:0] zone_number;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        result_kind;
        logic              status_code;
        logic [ZONE_W-1:0] zone_out;
        logic              last_result;
    } out_item_t;

    typedef struct packed {
        logic [2:0]        op;
        logic [ID_W-1:0]   sensor_id;
        logic              del_ok;
        logic [SLOT_W-1:0] del_slot;
    } cmd_t;

    function automatic logic [ZONE_W-1:0] zone_of(input logic [SLOT_W-1:0] slot);
        logic [SLOT_W+ZONE_W:0] sum;
        sum = (SLOT_W + ZONE_W + 1)'(slot) + (SLOT_W + ZONE_W + 1)'(FIRST_ZONE);
        return sum[ZONE_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/sensor_id_table_with_supervision.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Handshake          | Beat payload
// ---------+--------------------+---------------------------------------------
// in       | in_valid/in_ready  | in_item_t: action, sensor_id, zone_number
// out      | out_valid/out_ready| out_item_t: result_kind, status_code,
//          |                    |   zone_out, last_result
// cfg      | cfg_we (no wait)   | cfg_wdata: supervision limit
//
// Walk: lookup and add walk the slots from slot 0 and stop at the first hit or
// the last slot; delete and unknown actions do not walk; tick and report visit
// every slot, one slot per cycle unless a result is stalled, then send an end beat.
// Reset: all slots empty, counts and overdue marks cleared, limit 84.
// Stalls: a two-entry command queue accepts beats until it is full while the
// back end walks or waits on a full result register; the walk pauses only on
// a slot that has a result to send while the result register is still held.
module sensor_id_table_with_supervision
    import stid_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire in_item_t   in_data,
    output logic            out_valid,
    input  wire logic       out_ready,
    output out_item_t       out_data,
    input  wire logic       cfg_we,
    input  wire logic [7:0] cfg_wdata
);

    logic cmd_valid;
    logic cmd_pop;
    cmd_t cmd_head;

    // front: decode action, check the delete zone, queue the command
    stid_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cmd_valid (cmd_valid),
        .cmd_head  (cmd_head),
        .cmd_pop   (cmd_pop)
    );

    // back: slot table, supervision counters, result register
    stid_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd_valid (cmd_valid),
        .cmd_head  (cmd_head),
        .cmd_pop   (cmd_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

// ----- rtl/core/stid_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Classifies incoming beats and holds them in a short command queue.
module stid_front
    import stid_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire in_item_t in_data,
    output logic          cmd_valid,
    output cmd_t          cmd_head,
    input  wire logic     cmd_pop
);

    cmd_t                q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    cmd_t                cmd_new;
    logic [ZONE_IN_W:0]  zone_off;
    logic                push;

    // classify
    always_comb
    begin
        zone_off          = {1'b0, in_data.zone_number} - (ZONE_IN_W + 1)'(FIRST_ZONE);
        cmd_new.sensor_id = in_data.sensor_id;
        cmd_new.del_ok    = !zone_off[ZONE_IN_W] && (zone_off < (ZONE_IN_W + 1)'(ENTRIES));
        cmd_new.del_slot  = zone_off[SLOT_W-1:0];
        unique case (in_data.action)
            ACT_LOOKUP: cmd_new.op = OP_LOOKUP;
            ACT_ADD:    cmd_new.op = OP_ADD;
            ACT_DELETE: cmd_new.op = OP_DELETE;
            ACT_TICK:   cmd_new.op = OP_TICK;
            ACT_REPORT: cmd_new.op = OP_REPORT;
            default:    cmd_new.op = OP_BAD;
        endcase
    end

    assign in_ready  = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd_head  = q_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (cmd_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !cmd_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && cmd_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cmd_new;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/stid_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Executes queued commands: walks the slot table one slot per cycle while no
// result is stalled on the held result register, and drives the result register.
module stid_back
    import stid_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [7:0] cfg_wdata,
    input  wire logic       cmd_valid,
    input  wire cmd_t       cmd_head,
    output logic            cmd_pop,
    output logic            out_valid,
    input  wire logic       out_ready,
    output out_item_t       out_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_END  = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    cmd_t              cmd_reg, cmd_next;
    logic [CNT_W-1:0]  limit_reg;

    logic [ID_W-1:0]   id_store_reg [ENTRIES];
    logic [ID_W-1:0]   id_store_next [ENTRIES];
    logic [CNT_W-1:0]  cnt_reg [ENTRIES];
    logic [CNT_W-1:0]  cnt_next [ENTRIES];
    logic [ENTRIES-1:0] od_reg, od_next;

    logic              out_valid_reg, out_valid_next;
    out_item_t         out_data_reg, out_data_next;

    logic [ID_W-1:0]   cur_id;
    logic [CNT_W-1:0]  cur_cnt;
    logic              cur_od;
    logic              used;
    logic              last_slot;
    logic              out_can;
    logic              below;
    logic [CNT_W:0]    cnt_inc;
    logic              ev;
    logic              emit;
    out_item_t         res;

    assign cur_id    = id_store_reg[slot_reg];
    assign cur_cnt   = cnt_reg[slot_reg];
    assign cur_od    = od_reg[slot_reg];
    assign used      = (cur_id[ID_W-1 -: 8] != 8'd0);
    assign last_slot = (slot_reg == SLOT_W'(ENTRIES - 1));
    assign out_can   = !out_valid_reg || out_ready;
    assign below     = (cur_cnt < limit_reg);
    assign cnt_inc   = {1'b0, cur_cnt} + 1'b1;

    always_comb
    begin
        state_next    = state_reg;
        slot_next     = slot_reg;
        cmd_next      = cmd_reg;
        id_store_next = id_store_reg;
        cnt_next      = cnt_reg;
        od_next       = od_reg;
        cmd_pop       = 1'b0;
        emit          = 1'b0;
        ev            = 1'b0;
        res           = '{result_kind: KIND_ANSWER, status_code: STAT_FAIL,
                          zone_out: '0, last_result: 1'b1};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop    = 1'b1;
                    cmd_next   = cmd_head;
                    slot_next  = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                unique case (cmd_reg.op) inside
                    OP_LOOKUP:
                    begin
                        if (cur_id == cmd_reg.sensor_id || last_slot)
                        begin
                            if (out_can)
                            begin
                                emit = 1'b1;
                                if (cur_id == cmd_reg.sensor_id)
                                begin
                                    res.status_code = STAT_OK;
                                    res.zone_out    = zone_of(slot_reg);
                                end
                                state_next = ST_IDLE;
                            end
                        end
                        else
                        begin
                            slot_next = slot_reg + 1'b1;
                        end
                    end
                    OP_ADD:
                    begin
                        if (!used || last_slot)
                        begin
                            if (out_can)
                            begin
                                emit = 1'b1;
                                if (!used)
                                begin
                                    id_store_next[slot_reg] = cmd_reg.sensor_id;
                                    cnt_next[slot_reg]      = '0;
                                    od_next[slot_reg]       = 1'b0;
                                    res.status_code         = STAT_OK;
                                    res.zone_out            = zone_of(slot_reg);
                                end
                                state_next = ST_IDLE;
                            end
                        end
                        else
                        begin
                            slot_next = slot_reg + 1'b1;
                        end
                    end
                    OP_DELETE:
                    begin
                        if (out_can)
                        begin
                            emit = 1'b1;
                            if (cmd_reg.del_ok)
                            begin
                                id_store_next[cmd_reg.del_slot] = '0;
                                cnt_next[cmd_reg.del_slot]      = '0;
                                od_next[cmd_reg.del_slot]       = 1'b0;
                                res.status_code                 = STAT_OK;
                                res.zone_out                    = zone_of(cmd_reg.del_slot);
                            end
                            state_next = ST_IDLE;
                        end
                    end
                    OP_TICK, OP_REPORT:
                    begin
                        // tick: overdue slots repeat the event; other used slots count up while below the limit
                        if (cmd_reg.op == OP_TICK)
                        begin
                            ev = used && (cur_od || (below && cnt_inc >= {1'b0, limit_reg}));
                        end
                        else
                        begin
                            ev = used && cur_od;
                        end
                        if (!ev || out_can)
                        begin
                            if (cmd_reg.op == OP_TICK && used && !cur_od && below)
                            begin
                                cnt_next[slot_reg] = cnt_inc[CNT_W-1:0];
                                if (cnt_inc >= {1'b0, limit_reg})
                                begin
                                    od_next[slot_reg] = 1'b1;
                                end
                            end
                            emit            = ev;
                            res.result_kind = KIND_EVENT;
                            res.status_code = STAT_OK;
                            res.zone_out    = zone_of(slot_reg);
                            res.last_result = 1'b0;
                            if (last_slot)
                            begin
                                state_next = ST_END;
                            end
                            else
                            begin
                                slot_next = slot_reg + 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        if (out_can)
                        begin
                            emit       = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                endcase
            end
            ST_END:
            begin
                if (out_can)
                begin
                    emit            = 1'b1;
                    res.result_kind = KIND_END;
                    res.status_code = STAT_OK;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
            limit_reg     <= LIMIT_RESET;
            od_reg        <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                id_store_reg[i] <= '0;
                cnt_reg[i]      <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            out_valid_reg <= out_valid_next;
            od_reg        <= od_next;
            id_store_reg  <= id_store_next;
            cnt_reg       <= cnt_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

// ----- rtl/core/stid_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module stid_checker
    import stid_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      out_valid,
    input wire logic      out_ready,
    input wire out_item_t out_data
);

    // a held result beat stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // events are never the closing beat of an item
    a_event_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.result_kind == KIND_EVENT |-> !out_data.last_result)
        else $error("event marked last");

    // end beat closes the item, carries no zone
    a_end_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.result_kind == KIND_END
        |-> out_data.last_result && out_data.zone_out == '0
            && out_data.status_code == STAT_OK)
        else $error("malformed end beat");

    // a failed answer reports no zone
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status_code == STAT_FAIL
        |-> out_data.zone_out == '0 && out_data.result_kind == KIND_ANSWER)
        else $error("failed answer with zone");

    // successful answers and events name a real zone
    a_zone_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status_code == STAT_OK && out_data.result_kind != KIND_END
        |-> out_data.zone_out >= ZONE_W'(FIRST_ZONE))
        else $error("zone below first zone");

endmodule

bind sensor_id_table_with_supervision stid_checker u_stid_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire
